### design/evt_pkg.sv
// Package for the endpoint vote tally: beat types, FSM states and count helpers.
package evt_pkg;

   // Default table depth
   localparam int ENTRIES_DEF = 64;

   // Widest count the tables need (up to 1024 entries)
   localparam int CNT_MAX_W = 11;

   // Saturation limit of reported counts
   localparam logic [6:0] CNT_SAT = 7'd127;

   // Reset value of the time to live register
   localparam logic [31:0] TTL_RESET = 32'd300;

   // Command codes
   localparam logic CMD_ADD     = 1'b0;
   localparam logic CMD_COLLECT = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [47:0] source_endpoint;
      logic [47:0] external_endpoint;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic [6:0]  tally_for_claimed;
      logic [47:0] best_endpoint;
      logic        best_valid;
      logic        dropped_full;
      logic [6:0]  removed_count;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_S_SCAN,
      ST_DROP_RD,
      ST_DROP_WR,
      ST_T_SCAN,
      ST_COMMIT,
      ST_C_RD,
      ST_C_CHK,
      ST_C_TWR,
      ST_B_SCAN,
      ST_DONE
   } state_type;

   // Clamp a count to the 7-bit result range
   function automatic logic [6:0] sat_count(input logic [CNT_MAX_W-1:0] v);
      logic [6:0] r;
      if (v > CNT_MAX_W'(CNT_SAT)) begin
         r = CNT_SAT;
      end else begin
         r = v[6:0];
      end
      return r;
   endfunction

endpackage

### design/evt_stmt_mem.sv
// Statement table: source, tally pointer and stamp memory with valid flags.
module evt_stmt_mem #(
   parameter int ENTRIES = evt_pkg::ENTRIES_DEF,
   parameter int AW      = $clog2(ENTRIES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_valid,
   output logic [47:0]   rd_source,
   output logic [AW-1:0] rd_tptr,
   output logic [31:0]   rd_stamp,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_valid,
   input  logic [47:0]   wr_source,
   input  logic [AW-1:0] wr_tptr,
   input  logic [31:0]   wr_stamp
);

   logic [47:0]   source_mem [ENTRIES];
   logic [AW-1:0] tptr_mem   [ENTRIES];
   logic [31:0]   stamp_mem  [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;

   logic          rd_valid_ff;
   logic [47:0]   rd_source_ff;
   logic [AW-1:0] rd_tptr_ff;
   logic [31:0]   rd_stamp_ff;

   // Write payload and read through a registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         source_mem[wr_addr] <= wr_source;
         tptr_mem[wr_addr]   <= wr_tptr;
         stamp_mem[wr_addr]  <= wr_stamp;
      end
      rd_source_ff <= source_mem[rd_addr];
      rd_tptr_ff   <= tptr_mem[rd_addr];
      rd_stamp_ff  <= stamp_mem[rd_addr];
   end

   // Hold valid flags, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= wr_valid;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_valid  = rd_valid_ff;
   assign rd_source = rd_source_ff;
   assign rd_tptr   = rd_tptr_ff;
   assign rd_stamp  = rd_stamp_ff;

endmodule

### design/evt_tally_mem.sv
// Tally table: endpoint and count memory with valid flags.
module evt_tally_mem #(
   parameter int ENTRIES = evt_pkg::ENTRIES_DEF,
   parameter int AW      = $clog2(ENTRIES),
   parameter int CW      = $clog2(ENTRIES + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_valid,
   output logic [47:0]   rd_endpoint,
   output logic [CW-1:0] rd_count,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_valid,
   input  logic [47:0]   wr_endpoint,
   input  logic [CW-1:0] wr_count
);

   logic [47:0]   endpoint_mem [ENTRIES];
   logic [CW-1:0] count_mem    [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;

   logic          rd_valid_ff;
   logic [47:0]   rd_endpoint_ff;
   logic [CW-1:0] rd_count_ff;

   // Write payload and read through a registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         endpoint_mem[wr_addr] <= wr_endpoint;
         count_mem[wr_addr]    <= wr_count;
      end
      rd_endpoint_ff <= endpoint_mem[rd_addr];
      rd_count_ff    <= count_mem[rd_addr];
   end

   // Hold valid flags, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= wr_valid;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_valid    = rd_valid_ff;
   assign rd_endpoint = rd_endpoint_ff;
   assign rd_count    = rd_count_ff;

endmodule

### design/endpoint_vote_tally_with_expiry.sv
// Top level of the endpoint vote tally: sequencer over the statement and tally tables.
// Usage:
//   req_*  : one beat per statement (cmd add) or expiry sweep (cmd collect).
//   rsp_*  : exactly one result beat per request beat, in order.
//   csr_*  : write of time_to_live, taken only while the block is idle.
// Sequencing: an item is taken only while the sequencer is idle.
//   add     : statement scan, earlier-statement drop (only when the source
//             already had one), tally scan, commit, best scan, then result
//             load; the sequencer returns to idle before the next accept.
//   collect : one read and check per entry, a tally write per expired entry
//             and a step to close the walk, then best scan and result load;
//             the walk is skipped when now_seconds is below time_to_live.
//   Each walk goes entry by entry over the single read port of each table.
// The result sits in an output register; a stalled receiver holds it there
// while the next request is already worked on, and only the final result
// load waits for the register to free.
// Reset clears both valid flag sets at once (no clearing pass) and loads
// time_to_live with 300.
module endpoint_vote_tally_with_expiry #(
   parameter int ENTRIES = evt_pkg::ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  evt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output evt_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);

   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [AW:0] SCAN_END = (AW+1)'(ENTRIES);

   evt_pkg::state_type state_ff, state_in;

   // Latched item
   logic        cmd_ff, cmd_in;
   logic [47:0] src_ff, src_in;
   logic [47:0] ext_ff, ext_in;
   logic [31:0] now_ff, now_in;
   logic        lim_ok_ff, lim_ok_in;
   logic [31:0] limit_ff, limit_in;
   logic [31:0] ttl_ff, ttl_in;

   // Scan control
   logic [AW:0]   cnt_ff, cnt_in;
   logic          chk_ff, chk_in;
   logic [AW-1:0] chk_idx_ff, chk_idx_in;

   // Scan findings
   logic          sm_found_ff, sm_found_in;
   logic [AW-1:0] sm_idx_ff, sm_idx_in;
   logic [AW-1:0] sm_tptr_ff, sm_tptr_in;
   logic          sf_found_ff, sf_found_in;
   logic [AW-1:0] sf_idx_ff, sf_idx_in;
   logic          tm_found_ff, tm_found_in;
   logic [AW-1:0] tm_idx_ff, tm_idx_in;
   logic [CW-1:0] tm_cnt_ff, tm_cnt_in;
   logic          tf_found_ff, tf_found_in;
   logic [AW-1:0] tf_idx_ff, tf_idx_in;
   logic          any_ff, any_in;
   logic [CW-1:0] best_cnt_ff, best_cnt_in;
   logic [47:0]   best_ep_ff, best_ep_in;

   // Result accumulation
   logic [6:0]    claimed_ff, claimed_in;
   logic          dropped_ff, dropped_in;
   logic [CW-1:0] removed_ff, removed_in;

   // Tally pointer of the statement being expired
   logic [AW-1:0] t_rd_addr_hold_ff, t_rd_addr_hold_in;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   evt_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Memory ports
   logic [AW-1:0] s_rd_addr, s_wr_addr, s_wr_tptr, s_rd_tptr;
   logic          s_rd_valid, s_wr_en, s_wr_valid;
   logic [47:0]   s_rd_source, s_wr_source;
   logic [31:0]   s_rd_stamp, s_wr_stamp;
   logic [AW-1:0] t_rd_addr, t_wr_addr;
   logic          t_rd_valid, t_wr_en, t_wr_valid;
   logic [47:0]   t_rd_endpoint, t_wr_endpoint;
   logic [CW-1:0] t_rd_count, t_wr_count;

   logic          req_beat, out_free, scan_issue, scan_done, expired;
   logic [CW-1:0] dec_count, new_count;
   logic [AW-1:0] s_sel, t_sel;
   logic          commit_ok;

   evt_stmt_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_stmt (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (s_rd_addr),
      .rd_valid  (s_rd_valid),
      .rd_source (s_rd_source),
      .rd_tptr   (s_rd_tptr),
      .rd_stamp  (s_rd_stamp),
      .wr_en     (s_wr_en),
      .wr_addr   (s_wr_addr),
      .wr_valid  (s_wr_valid),
      .wr_source (s_wr_source),
      .wr_tptr   (s_wr_tptr),
      .wr_stamp  (s_wr_stamp)
   );

   evt_tally_mem #(.ENTRIES(ENTRIES), .AW(AW), .CW(CW)) u_tally (
      .clock       (clock),
      .reset       (reset),
      .rd_addr     (t_rd_addr),
      .rd_valid    (t_rd_valid),
      .rd_endpoint (t_rd_endpoint),
      .rd_count    (t_rd_count),
      .wr_en       (t_wr_en),
      .wr_addr     (t_wr_addr),
      .wr_valid    (t_wr_valid),
      .wr_endpoint (t_wr_endpoint),
      .wr_count    (t_wr_count)
   );

   // Shared helper terms
   assign req_beat   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign scan_issue = cnt_ff < SCAN_END;
   assign scan_done  = !scan_issue && !chk_ff;
   assign expired    = s_rd_valid && (s_rd_stamp < limit_ff);
   assign dec_count  = (t_rd_count != '0) ? (t_rd_count - CW'(1)) : '0;
   assign new_count  = tm_found_ff ? (tm_cnt_ff + CW'(1)) : CW'(1);
   assign s_sel      = sm_found_ff ? sm_idx_ff : sf_idx_ff;
   assign t_sel      = tm_found_ff ? tm_idx_ff : tf_idx_ff;
   assign commit_ok  = (sm_found_ff || sf_found_ff) && (tm_found_ff || tf_found_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         evt_pkg::ST_IDLE: begin
            if (req_beat) begin
               state_in = (req_data.cmd == evt_pkg::CMD_COLLECT) ?
                          evt_pkg::ST_C_RD : evt_pkg::ST_S_SCAN;
            end
         end
         evt_pkg::ST_S_SCAN: begin
            if (scan_done) begin
               state_in = sm_found_ff ? evt_pkg::ST_DROP_RD : evt_pkg::ST_T_SCAN;
            end
         end
         evt_pkg::ST_DROP_RD: state_in = evt_pkg::ST_DROP_WR;
         evt_pkg::ST_DROP_WR: state_in = evt_pkg::ST_T_SCAN;
         evt_pkg::ST_T_SCAN: begin
            if (scan_done) begin
               state_in = evt_pkg::ST_COMMIT;
            end
         end
         evt_pkg::ST_COMMIT: state_in = evt_pkg::ST_B_SCAN;
         evt_pkg::ST_C_RD: begin
            if (!lim_ok_ff || (cnt_ff == SCAN_END)) begin
               state_in = evt_pkg::ST_B_SCAN;
            end else begin
               state_in = evt_pkg::ST_C_CHK;
            end
         end
         evt_pkg::ST_C_CHK: state_in = expired ? evt_pkg::ST_C_TWR : evt_pkg::ST_C_RD;
         evt_pkg::ST_C_TWR: state_in = evt_pkg::ST_C_RD;
         evt_pkg::ST_B_SCAN: begin
            if (scan_done) begin
               state_in = evt_pkg::ST_DONE;
            end
         end
         evt_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = evt_pkg::ST_IDLE;
            end
         end
         default: state_in = evt_pkg::ST_IDLE;
      endcase
   end

   // FSM outputs: handshakes and memory controls
   always_comb begin
      req_ready     = 1'b0;
      csr_ready     = 1'b0;
      s_rd_addr     = cnt_ff[AW-1:0];
      t_rd_addr     = cnt_ff[AW-1:0];
      s_wr_en       = 1'b0;
      s_wr_addr     = s_sel;
      s_wr_valid    = 1'b0;
      s_wr_source   = src_ff;
      s_wr_tptr     = t_sel;
      s_wr_stamp    = now_ff;
      t_wr_en       = 1'b0;
      t_wr_addr     = t_sel;
      t_wr_valid    = 1'b1;
      t_wr_endpoint = ext_ff;
      t_wr_count    = new_count;
      unique case (state_ff)
         evt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            csr_ready = 1'b1;
         end
         evt_pkg::ST_DROP_RD: t_rd_addr = sm_tptr_ff;
         evt_pkg::ST_DROP_WR: begin
            // drop the earlier statement of this source
            t_wr_en       = 1'b1;
            t_wr_addr     = sm_tptr_ff;
            t_wr_valid    = (dec_count != '0);
            t_wr_endpoint = t_rd_endpoint;
            t_wr_count    = dec_count;
            s_wr_en       = 1'b1;
            s_wr_addr     = sm_idx_ff;
            s_wr_valid    = 1'b0;
         end
         evt_pkg::ST_COMMIT: begin
            s_wr_en    = commit_ok;
            s_wr_valid = 1'b1;
            t_wr_en    = commit_ok;
         end
         evt_pkg::ST_C_CHK: begin
            // expire: clear the statement, fetch its tally
            t_rd_addr  = s_rd_tptr;
            s_wr_en    = expired;
            s_wr_addr  = cnt_ff[AW-1:0];
            s_wr_valid = 1'b0;
         end
         evt_pkg::ST_C_TWR: begin
            t_wr_en       = 1'b1;
            t_wr_addr     = t_rd_addr_hold_ff;
            t_wr_valid    = (dec_count != '0);
            t_wr_endpoint = t_rd_endpoint;
            t_wr_count    = dec_count;
         end
         evt_pkg::ST_S_SCAN, evt_pkg::ST_T_SCAN, evt_pkg::ST_B_SCAN,
         evt_pkg::ST_C_RD, evt_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      cmd_in = cmd_ff;  src_in = src_ff;  ext_in = ext_ff;  now_in = now_ff;
      lim_ok_in = lim_ok_ff;  limit_in = limit_ff;  ttl_in = ttl_ff;
      cnt_in = cnt_ff;  chk_in = 1'b0;  chk_idx_in = chk_idx_ff;
      sm_found_in = sm_found_ff;  sm_idx_in = sm_idx_ff;  sm_tptr_in = sm_tptr_ff;
      sf_found_in = sf_found_ff;  sf_idx_in = sf_idx_ff;
      tm_found_in = tm_found_ff;  tm_idx_in = tm_idx_ff;  tm_cnt_in = tm_cnt_ff;
      tf_found_in = tf_found_ff;  tf_idx_in = tf_idx_ff;
      any_in = any_ff;  best_cnt_in = best_cnt_ff;  best_ep_in = best_ep_ff;
      claimed_in = claimed_ff;  dropped_in = dropped_ff;  removed_in = removed_ff;
      t_rd_addr_hold_in = t_rd_addr_hold_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_data_in = rsp_data_ff;

      // Take a configuration beat
      if (csr_valid && csr_ready) begin
         ttl_in = csr_data;
      end

      // Advance a pipelined scan: issue now, check next cycle
      if ((state_ff == evt_pkg::ST_S_SCAN) || (state_ff == evt_pkg::ST_T_SCAN) ||
          (state_ff == evt_pkg::ST_B_SCAN)) begin
         if (scan_issue) begin
            cnt_in     = cnt_ff + (AW+1)'(1);
            chk_in     = 1'b1;
            chk_idx_in = cnt_ff[AW-1:0];
         end
      end

      case (state_ff)
         evt_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (req_beat) begin
               cmd_in      = req_data.cmd;
               src_in      = req_data.source_endpoint;
               ext_in      = req_data.external_endpoint;
               now_in      = req_data.now_seconds;
               lim_ok_in   = (req_data.now_seconds >= ttl_ff);
               limit_in    = req_data.now_seconds - ttl_ff;
               sm_found_in = 1'b0;
               sf_found_in = 1'b0;
               tm_found_in = 1'b0;
               tf_found_in = 1'b0;
               any_in      = 1'b0;
               best_cnt_in = '0;
               best_ep_in  = '0;
               claimed_in  = '0;
               dropped_in  = 1'b0;
               removed_in  = '0;
            end
         end
         evt_pkg::ST_S_SCAN: begin
            if (chk_ff) begin
               if (s_rd_valid && (s_rd_source == src_ff) && !sm_found_ff) begin
                  sm_found_in = 1'b1;
                  sm_idx_in   = chk_idx_ff;
                  sm_tptr_in  = s_rd_tptr;
               end
               if (!s_rd_valid && !sf_found_ff) begin
                  sf_found_in = 1'b1;
                  sf_idx_in   = chk_idx_ff;
               end
            end
            if (scan_done) begin
               cnt_in = '0;
            end
         end
         evt_pkg::ST_T_SCAN: begin
            if (chk_ff) begin
               if (t_rd_valid && (t_rd_endpoint == ext_ff) && !tm_found_ff) begin
                  tm_found_in = 1'b1;
                  tm_idx_in   = chk_idx_ff;
                  tm_cnt_in   = t_rd_count;
               end
               if (!t_rd_valid && !tf_found_ff) begin
                  tf_found_in = 1'b1;
                  tf_idx_in   = chk_idx_ff;
               end
            end
         end
         evt_pkg::ST_COMMIT: begin
            cnt_in = '0;
            if (commit_ok) begin
               claimed_in = evt_pkg::sat_count(evt_pkg::CNT_MAX_W'(new_count));
            end else begin
               dropped_in = 1'b1;
            end
         end
         evt_pkg::ST_C_RD: begin
            if (!lim_ok_ff || (cnt_ff == SCAN_END)) begin
               cnt_in = '0;
            end
         end
         evt_pkg::ST_C_CHK: begin
            if (expired) begin
               removed_in        = removed_ff + CW'(1);
               t_rd_addr_hold_in = s_rd_tptr;
            end else begin
               cnt_in = cnt_ff + (AW+1)'(1);
            end
         end
         evt_pkg::ST_C_TWR: cnt_in = cnt_ff + (AW+1)'(1);
         evt_pkg::ST_B_SCAN: begin
            if (chk_ff && t_rd_valid) begin
               if (!any_ff || (t_rd_count > best_cnt_ff) ||
                   ((t_rd_count == best_cnt_ff) && (t_rd_endpoint < best_ep_ff))) begin
                  any_in      = 1'b1;
                  best_cnt_in = t_rd_count;
                  best_ep_in  = t_rd_endpoint;
               end
            end
         end
         default: begin
         end
      endcase

      // Drop a taken result beat, load a finished one
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == evt_pkg::ST_DONE) && out_free) begin
         rsp_valid_in                  = 1'b1;
         rsp_data_in.tally_for_claimed = claimed_ff;
         rsp_data_in.best_endpoint     = any_ff ? best_ep_ff : 48'd0;
         rsp_data_in.best_valid        = any_ff;
         rsp_data_in.dropped_full      = dropped_ff;
         rsp_data_in.removed_count     = evt_pkg::sat_count(evt_pkg::CNT_MAX_W'(removed_ff));
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= evt_pkg::ST_IDLE;
         ttl_ff       <= evt_pkg::TTL_RESET;
         cnt_ff       <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ttl_ff       <= ttl_in;
         cnt_ff       <= cnt_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;  src_ff <= src_in;  ext_ff <= ext_in;  now_ff <= now_in;
      lim_ok_ff <= lim_ok_in;  limit_ff <= limit_in;
      chk_idx_ff <= chk_idx_in;
      sm_found_ff <= sm_found_in;  sm_idx_ff <= sm_idx_in;  sm_tptr_ff <= sm_tptr_in;
      sf_found_ff <= sf_found_in;  sf_idx_ff <= sf_idx_in;
      tm_found_ff <= tm_found_in;  tm_idx_ff <= tm_idx_in;  tm_cnt_ff <= tm_cnt_in;
      tf_found_ff <= tf_found_in;  tf_idx_ff <= tf_idx_in;
      any_ff <= any_in;  best_cnt_ff <= best_cnt_in;  best_ep_ff <= best_ep_in;
      claimed_ff <= claimed_in;  dropped_ff <= dropped_in;  removed_ff <= removed_in;
      t_rd_addr_hold_ff <= t_rd_addr_hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Empty best endpoint whenever no statement is kept
   a_best_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.best_valid || (rsp_data.best_endpoint == 48'd0)))
      else $error("best_endpoint set without kept statements");

   // A dropped statement backs nothing
   a_drop_claim: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.dropped_full) |-> (rsp_data.tally_for_claimed == 7'd0))
      else $error("dropped statement reports a tally");

   // Removal only comes from a collect beat, which never claims or drops
   a_remove_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.removed_count != 7'd0)) |->
      (!rsp_data.dropped_full && (rsp_data.tally_for_claimed == 7'd0)))
      else $error("collect result mixed with add fields");

   // Neither the statement nor the tally table is written while idle
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == evt_pkg::ST_IDLE) |-> (!s_wr_en && !t_wr_en))
      else $error("table write while idle");

endmodule
